### design/slcd_pkg.sv
// Package: constants, field widths and phase type for the frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 17;
  localparam int unsigned LengthW = 16;
  localparam int unsigned StatusW = 2;

  // Output tdata: frame_byte, byte_index, data_length, padded to whole bytes
  localparam int unsigned OutRawW  = ByteW + IndexW + LengthW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - OutRawW;

  localparam logic [ByteW-1:0] SyncFirst  = 8'hA5;
  localparam logic [ByteW-1:0] SyncSecond = 8'h01;
  localparam logic [ByteW-1:0] CheckXor   = 8'h01;

  // Check code sits at index L + CheckOffset; the length bytes at fixed spots
  localparam logic [IndexW-1:0] CheckOffset = 17'd7;
  localparam logic [IndexW-1:0] IdxLenLo    = 17'd3;
  localparam logic [IndexW-1:0] IdxLenHi    = 17'd4;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

endpackage : slcd_pkg

`default_nettype wire

### design/sync_length_checksum_deframer.sv
// Top level: byte-stream deframer with sync, length and checksum tracking.
//
// Usage:
//   Received bytes enter on the in_ channel, one per beat (in_tdata[7:0]).
//   Bytes outside a frame are dropped. Each frame byte leaves on the out_
//   channel with its index in the frame and the length field as assembled
//   so far; the check code byte leaves with out_tlast high and out_tuser
//   holding the verdict (1 good, 2 checksum error). A broken header byte is
//   dropped and hunting resumes; a 0xA5 in that place restarts the header.
//   A byte accepted passes through the input register, then moves to the
//   result register, from which it is shown on out_.
//   Throughput: one byte per cycle; a new byte is taken in every cycle
//   while the result register is empty or being taken.
//   Stall: when out_tready is low, the result register holds its beat and
//   the input register holds one more byte; in_tready falls only when both
//   are full. The frame state advances only as bytes leave the input
//   register, so no beat is lost or repeated.
//   Reset (rst_n low, synchronous): both registers empty, phase back to
//   hunting, index, length and sum cleared.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_checksum_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [slcd_pkg::ByteW-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [7:0] frame_byte, [24:8] byte_index, [40:25] data_length, rest zero
  output logic [slcd_pkg::OutDataW-1:0]      out_tdata,
  output logic                               out_tlast,
  output logic [slcd_pkg::StatusW-1:0]       out_tuser   // [1:0] status
);
  import slcd_pkg::*;

  // Input register
  logic             in_v_r;
  logic [ByteW-1:0] in_b_r;

  // Frame state
  phase_t             phase_r, phase_nxt;
  logic [IndexW-1:0]  pos_r, pos_nxt;
  logic [LengthW-1:0] len_r, len_nxt;
  logic [ByteW-1:0]   sum_r, sum_nxt;

  // Result register
  logic               out_v_r;
  logic [ByteW-1:0]   res_b_r, res_b_nxt;
  logic [IndexW-1:0]  res_idx_r, res_idx_nxt;
  logic [LengthW-1:0] res_len_r, res_len_nxt;
  logic               res_last_r, res_last_nxt;
  status_t            res_st_r, res_st_nxt;
  logic               res_v_nxt;

  logic               adv;
  logic               step;
  logic [LengthW-1:0] len_cur;
  logic [ByteW-1:0]   code;
  logic               at_check;

  // Result register can take a new beat when empty or being drained
  assign adv       = !out_v_r || out_tready;
  assign step      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  // Length field as it stands after this byte, and expected check code
  always_comb begin
    len_cur = len_r;
    if (pos_r == IdxLenLo) begin
      len_cur = {{(LengthW-ByteW){1'b0}}, in_b_r};
    end else if (pos_r == IdxLenHi) begin
      len_cur = {in_b_r, len_r[ByteW-1:0]};
    end
  end

  assign code     = (~sum_r + 8'd1) ^ CheckXor;
  assign at_check = (pos_r > IdxLenHi) && (pos_r == ({1'b0, len_cur} + CheckOffset));

  // Next frame state and result beat for the byte in the input register
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    res_v_nxt    = 1'b0;
    res_b_nxt    = in_b_r;
    res_idx_nxt  = pos_r;
    res_len_nxt  = len_r;
    res_last_nxt = 1'b0;
    res_st_nxt   = ST_BUSY;
    case (phase_r)
      PH_SYNC: begin
        if (in_b_r == SyncSecond) begin
          sum_nxt     = sum_r + in_b_r;
          res_v_nxt   = 1'b1;
          res_idx_nxt = 17'd1;
          pos_nxt     = 17'd2;
          phase_nxt   = PH_BODY;
        end else if (in_b_r == SyncFirst) begin
          // restart the header
          phase_nxt   = PH_SYNC;
          len_nxt     = '0;
          sum_nxt     = SyncFirst;
          pos_nxt     = 17'd1;
          res_v_nxt   = 1'b1;
          res_idx_nxt = '0;
          res_len_nxt = '0;
        end else begin
          // drop the byte and resume hunting
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end
      end
      PH_BODY: begin
        len_nxt     = len_cur;
        res_len_nxt = len_cur;
        res_v_nxt   = 1'b1;
        if (at_check) begin
          res_last_nxt = 1'b1;
          res_st_nxt   = (code == in_b_r) ? ST_GOOD : ST_BAD;
          phase_nxt    = PH_HUNT;
          pos_nxt      = '0;
          sum_nxt      = '0;
        end else begin
          sum_nxt = sum_r + in_b_r;
          pos_nxt = pos_r + 17'd1;
        end
      end
      default: begin
        // hunting; also covers the unused phase code
        phase_nxt = PH_HUNT;
        pos_nxt   = '0;
        if (in_b_r == SyncFirst) begin
          phase_nxt   = PH_SYNC;
          len_nxt     = '0;
          sum_nxt     = SyncFirst;
          pos_nxt     = 17'd1;
          res_v_nxt   = 1'b1;
          res_idx_nxt = '0;
          res_len_nxt = '0;
        end
      end
    endcase
  end

  // Input register: load on accept, empty when its byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_b_r <= in_tdata;
    end
  end

  // Frame state: advance once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= step && res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_v_nxt) begin
      res_b_r    <= res_b_nxt;
      res_idx_r  <= res_idx_nxt;
      res_len_r  <= res_len_nxt;
      res_last_r <= res_last_nxt;
      res_st_r   <= res_st_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OutPadW{1'b0}}, res_len_r, res_idx_r, res_b_r};
  assign out_tlast  = res_last_r;
  assign out_tuser  = res_st_r;

endmodule : sync_length_checksum_deframer

`default_nettype wire

### design/slcd_checker.sv
// Checker: port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module slcd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [slcd_pkg::OutDataW-1:0] out_tdata,
  input wire logic                          out_tlast,
  input wire logic [slcd_pkg::StatusW-1:0]  out_tuser
);
  import slcd_pkg::*;

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // Verdict only on the check code beat
  a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ST_GOOD || out_tuser == ST_BAD)
    else $error("last beat without verdict");

  a_body_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == ST_BUSY)
    else $error("verdict on a non-last beat");

  // Check code lands at index L + 7
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[24:8] == ({1'b0, out_tdata[40:25]} + CheckOffset))
    else $error("check code beat at wrong index");

  // Frame start carries the first sync byte and a cleared length
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24:8] == '0 |->
      out_tdata[7:0] == SyncFirst && out_tdata[40:25] == '0)
    else $error("bad frame start beat");

endmodule : slcd_checker

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### verif/sync_length_checksum_deframer_tb.sv
// Testbench: directed and random byte streams through the frame deframer, checked beat by beat.
`timescale 1ns / 1ps

module sync_length_checksum_deframer_tb;
  import slcd_pkg::*;

  localparam int unsigned IdlePct   = 36;
  localparam int unsigned RandItems = 600;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [IndexW-1:0]  index;
    logic               is_last;
    status_t            status;
    logic [LengthW-1:0] len_field;
  } frame_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic [StatusW-1:0]  out_tuser;

  // Shadow copy of the deframer state
  phase_t             sh_phase = PH_HUNT;
  logic [IndexW-1:0]  sh_pos = '0;
  logic [LengthW-1:0] sh_len = '0;
  logic [ByteW-1:0]   sh_sum = '0;

  frame_beat_t pending_beats[$];
  int unsigned bytes_sent = 0;
  int unsigned err_count = 0;
  bit          no_idle = 1'b0;

  sync_length_checksum_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // Stall the result side at random unless a no-idle stretch is running
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  // Start a new frame on a first header byte
  function automatic void open_frame(output frame_beat_t r);
    sh_phase = PH_SYNC;
    sh_len   = '0;
    sh_sum   = SyncFirst;
    sh_pos   = 17'd1;
    r.data      = SyncFirst;
    r.index     = '0;
    r.is_last   = 1'b0;
    r.status    = ST_BUSY;
    r.len_field = '0;
  endfunction

  // Advance the shadow state by one received byte; return 1 if a beat is due
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output frame_beat_t r);
    logic [IndexW-1:0] idx;
    logic [ByteW-1:0]  code;
    r = '0;
    deframe_byte = 1'b0;
    case (sh_phase)
      PH_SYNC: begin
        if (b == SyncSecond) begin
          sh_sum      = sh_sum + b;
          r.data      = b;
          r.index     = 17'd1;
          r.status    = ST_BUSY;
          r.len_field = sh_len;
          sh_pos      = 17'd2;
          sh_phase    = PH_BODY;
          deframe_byte = 1'b1;
        end else if (b == SyncFirst) begin
          open_frame(r);
          deframe_byte = 1'b1;
        end else begin
          // drop the breaking byte and hunt again
          sh_phase = PH_HUNT;
          sh_pos   = '0;
        end
      end
      PH_BODY: begin
        idx = sh_pos;
        if (idx == IdxLenLo) begin
          sh_len = {8'h00, b};
        end else if (idx == IdxLenHi) begin
          sh_len[15:8] = b;
        end
        r.data      = b;
        r.index     = idx;
        r.len_field = sh_len;
        deframe_byte = 1'b1;
        if (idx > IdxLenHi && idx == {1'b0, sh_len} + CheckOffset) begin
          // check code byte closes the frame
          code      = (~sh_sum + 8'd1) ^ CheckXor;
          r.is_last = 1'b1;
          r.status  = (code == b) ? ST_GOOD : ST_BAD;
          sh_phase  = PH_HUNT;
          sh_pos    = '0;
          sh_sum    = '0;
        end else begin
          sh_sum   = sh_sum + b;
          r.status = ST_BUSY;
          sh_pos   = idx + 17'd1;
        end
      end
      default: begin
        sh_phase = PH_HUNT;
        sh_pos   = '0;
        if (b == SyncFirst) begin
          open_frame(r);
          deframe_byte = 1'b1;
        end
      end
    endcase
  endfunction

  // Offer one byte, idling at random first, and predict once it is taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    frame_beat_t r;
    while (!no_idle && ($urandom_range(99) < IdlePct)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (deframe_byte(b, r)) pending_beats.push_back(r);
  endtask

  // Send a frame of the given length; keep only the first cut_at bytes if cut_at is set.
  // Payload bytes lean toward header values to test that they are not taken as a header.
  task automatic send_frame(input int unsigned len, input bit good, input int unsigned cut_at);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int unsigned      total;
    total = len + 8;
    sum   = '0;
    for (int unsigned i = 0; i < total; i++) begin
      if (cut_at != 0 && i >= cut_at) break;
      case (i)
        0: b = SyncFirst;
        1: b = SyncSecond;
        3: b = len[7:0];
        4: b = len[15:8];
        default: begin
          case ($urandom_range(7))
            0: b = SyncFirst;
            1: b = SyncSecond;
            default: b = 8'($urandom_range(255));
          endcase
        end
      endcase
      if (i == total - 1) begin
        b = (~sum + 8'd1) ^ CheckXor;
        if (!good) b = b ^ 8'($urandom_range(255, 1));
      end
      sum = sum + b;
      send_byte(b);
    end
  endtask

  // Noise, broken headers, doubled header start, short frames and body header bytes
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncSecond);
    send_byte(SyncFirst);
    send_byte(8'h02);
    send_byte(SyncFirst);
    send_byte(8'hFF);
    send_byte(SyncFirst);
    send_frame(0, 1'b1, 0);
    send_frame(0, 1'b0, 0);
    send_frame(1, 1'b1, 0);
    send_frame(2, 1'b0, 0);
  endtask

  // Frame whose length field uses both bytes
  task automatic test_long_frame();
    send_frame(261, 1'b1, 0);
  endtask

  // Good frames back to back with both sides always ready
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (20) send_frame($urandom_range(12), 1'b1, 0);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed frames with random content, plus noise and broken sequences
  task automatic test_random();
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    goal = bytes_sent + RandItems;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(24);
      if (pick < 68) begin
        send_frame(len, 1'b1, 0);
      end else if (pick < 80) begin
        send_frame(len, 1'b0, 0);
      end else if (pick < 88) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else if (pick < 94) begin
        send_byte(SyncFirst);
        send_byte(($urandom_range(1) == 0) ? SyncFirst : 8'($urandom_range(255, 2)));
      end else begin
        send_frame(len, 1'b1, $urandom_range(len + 7, 1));
      end
    end
  endtask

  // Compare each result beat with the oldest expected one
  always @(posedge clk) begin
    frame_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: tdata %h tlast %b tuser %0d", out_tdata, out_tlast, out_tuser);
        err_count++;
      end else begin
        e = pending_beats.pop_front();
        if (out_tdata[ByteW-1:0] !== e.data) begin
          $error("frame_byte: expected %0h, got %0h", e.data, out_tdata[ByteW-1:0]);
          err_count++;
        end
        if (out_tdata[ByteW+IndexW-1:ByteW] !== e.index) begin
          $error("byte_index: expected %0d, got %0d", e.index,
                 out_tdata[ByteW+IndexW-1:ByteW]);
          err_count++;
        end
        if (out_tdata[OutRawW-1:ByteW+IndexW] !== e.len_field) begin
          $error("data_length: expected %0d, got %0d", e.len_field,
                 out_tdata[OutRawW-1:ByteW+IndexW]);
          err_count++;
        end
        if (out_tdata[OutDataW-1:OutRawW] !== '0) begin
          $error("tdata padding: expected 0, got %0h", out_tdata[OutDataW-1:OutRawW]);
          err_count++;
        end
        if (out_tlast !== e.is_last) begin
          $error("last: expected %b, got %b", e.is_last, out_tlast);
          err_count++;
        end
        if (out_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_tuser);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_long_frame();
    test_random();
    in_tvalid <= 1'b0;

    // Drain, then allow the pipeline latency for stray beats
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/slcd_pkg.sv
design/sync_length_checksum_deframer.sv
design/slcd_checker.sv
verif/sync_length_checksum_deframer_tb.sv
